// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define STERM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds through reset
`define STERM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/sterm_pkg.sv
// types, constants and tables for the solar term date pipeline
`timescale 1ns / 1ps
`default_nettype none
package sterm_pkg;

  localparam int YEAR_W   = 14;
  localparam int TERM_W   = 5;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 32;
  localparam int OUT_PAD  = OUT_W - (YEAR_W + MONTH_W + DAY_W + TERM_W);

  localparam int TMM_W    = 29;
  localparam int X1_W     = 33;
  localparam int QDAY_W   = 13;
  localparam int DN_W     = 23;
  localparam int QCYC_W   = 6;
  localparam int SC_W     = 30;
  localparam int EY_W     = 15;
  localparam int REM_W    = 16;
  localparam int QM_W     = 4;
  localparam int REM2_W   = 12;
  localparam int Q100_W   = 8;
  localparam int Q400_W   = 6;
  localparam int DIFF_W   = 25;
  localparam int DB_W     = 9;

  // time base in thousandths of a minute
  localparam longint unsigned MMIN_PER_DAY   = 64'd1440000;
  localparam longint unsigned EPOCH_MMIN     = 64'd693966 * 64'd1440000 + 64'd125000;
  localparam longint unsigned MEAN_YEAR_MMIN = 64'd525948768;
  localparam longint unsigned BASE_YEAR      = 64'd1900;
  localparam longint unsigned MMIN_PER_MIN   = 64'd1000;
  localparam longint unsigned YEAR_DAYS      = MEAN_YEAR_MMIN / MMIN_PER_DAY;
  localparam longint unsigned YEAR_FRAC_MMIN = MEAN_YEAR_MMIN % MMIN_PER_DAY;
  localparam longint unsigned BIAS_MMIN      = EPOCH_MMIN - MEAN_YEAR_MMIN * BASE_YEAR;

  localparam int              DAY_SHIFT      = 8;
  localparam longint unsigned DAY_ODD        = MMIN_PER_DAY >> DAY_SHIFT;

  localparam longint unsigned CYCLE_DAYS     = 64'd146097;
  localparam longint unsigned SCALED_YEAR    = 64'd36524;
  localparam longint unsigned SCALED_MONTH   = 64'd3044;
  localparam longint unsigned DAY_SCALE      = 64'd100;
  localparam longint unsigned CENTURY        = 64'd100;
  localparam longint unsigned QUAD_CENTURY   = 64'd400;

  // reciprocals: shift = dividend bits + divisor bits gives exact floor
  localparam int              RCP_DAY_SH  = (X1_W - DAY_SHIFT) + 13;
  localparam int              RCP_DAY_W   = 26;
  localparam longint unsigned RCP_DAY     = ((64'd1 << RCP_DAY_SH) + DAY_ODD - 1) / DAY_ODD;

  localparam int              RCP_CYC_SH  = DN_W + 18;
  localparam int              RCP_CYC_W   = 24;
  localparam longint unsigned RCP_CYC     =
    ((64'd1 << RCP_CYC_SH) + CYCLE_DAYS - 1) / CYCLE_DAYS;

  localparam int              RCP_YR_SH   = SC_W + 16;
  localparam int              RCP_YR_W    = 31;
  localparam longint unsigned RCP_YR      =
    ((64'd1 << RCP_YR_SH) + SCALED_YEAR - 1) / SCALED_YEAR;

  localparam int              RCP_MON_SH  = REM_W + 12;
  localparam int              RCP_MON_W   = 17;
  localparam longint unsigned RCP_MON     =
    ((64'd1 << RCP_MON_SH) + SCALED_MONTH - 1) / SCALED_MONTH;

  localparam int              RCP_DS_SH   = REM2_W + 7;
  localparam int              RCP_DS_W    = 13;
  localparam longint unsigned RCP_DS      = ((64'd1 << RCP_DS_SH) + DAY_SCALE - 1) / DAY_SCALE;

  localparam int              RCP_C_SH    = EY_W + 7;
  localparam int              RCP_C_W     = 16;
  localparam longint unsigned RCP_C       = ((64'd1 << RCP_C_SH) + CENTURY - 1) / CENTURY;

  localparam int              RCP_Q_SH    = EY_W + 9;
  localparam int              RCP_Q_W     = 16;
  localparam longint unsigned RCP_Q       =
    ((64'd1 << RCP_Q_SH) + QUAD_CENTURY - 1) / QUAD_CENTURY;

  localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
  localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [TERM_W-1:0] term;
  } sterm_in_t;

  typedef struct packed {
    logic [DN_W-1:0]   dn;
    logic [TERM_W-1:0] term;
  } sterm_dn_t;

  typedef struct packed {
    logic [EY_W-1:0]    y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
    logic [Q100_W-1:0]  y100;
    logic [Q400_W-1:0]  y400;
    logic [DN_W-1:0]    dn;
    logic [TERM_W-1:0]  term;
  } sterm_est_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [TERM_W-1:0]  term;
  } sterm_out_t;

  // term offset from minor cold, indices past winter solstice saturate
  function automatic logic [TMM_W-1:0] term_mmin(input logic [TERM_W-1:0] idx);
    logic [18:0] mins;
    case (idx)
      5'd0:    mins = 19'd0;
      5'd1:    mins = 19'd21208;
      5'd2:    mins = 19'd42467;
      5'd3:    mins = 19'd63836;
      5'd4:    mins = 19'd85337;
      5'd5:    mins = 19'd107014;
      5'd6:    mins = 19'd128867;
      5'd7:    mins = 19'd150921;
      5'd8:    mins = 19'd173149;
      5'd9:    mins = 19'd195551;
      5'd10:   mins = 19'd218072;
      5'd11:   mins = 19'd240693;
      5'd12:   mins = 19'd263343;
      5'd13:   mins = 19'd285989;
      5'd14:   mins = 19'd308563;
      5'd15:   mins = 19'd331033;
      5'd16:   mins = 19'd353350;
      5'd17:   mins = 19'd375494;
      5'd18:   mins = 19'd397447;
      5'd19:   mins = 19'd419210;
      5'd20:   mins = 19'd440795;
      5'd21:   mins = 19'd462224;
      5'd22:   mins = 19'd483532;
      default: mins = 19'd504758;
    endcase
    return TMM_W'(mins) * TMM_W'(MMIN_PER_MIN);
  endfunction

  function automatic logic [DB_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DB_W-1:0] db;
    case (m)
      4'd1:    db = 9'd0;
      4'd2:    db = 9'd31;
      4'd3:    db = 9'd59;
      4'd4:    db = 9'd90;
      4'd5:    db = 9'd120;
      4'd6:    db = 9'd151;
      4'd7:    db = 9'd181;
      4'd8:    db = 9'd212;
      4'd9:    db = 9'd243;
      4'd10:   db = 9'd273;
      4'd11:   db = 9'd304;
      4'd12:   db = 9'd334;
      default: db = 9'd0;
    endcase
    return db;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sterm_daynum.sv
// three-stage day number unit: year and term to whole days since day zero
`timescale 1ns / 1ps
`default_nettype none
module sterm_daynum (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    vld_i,
  input  sterm_pkg::sterm_in_t   data_i,
  output logic                   vld_o,
  output sterm_pkg::sterm_dn_t   data_o
);
  import sterm_pkg::*;

  localparam int P2_W = (X1_W - DAY_SHIFT) + RCP_DAY_W;

  logic [2:0]            vld_r;
  logic [TERM_W-1:0]     term_r [3];
  logic [YEAR_W-1:0]     year1_r;
  logic [YEAR_W-1:0]     year2_r;
  logic [X1_W-1:0]       x1_r;
  logic [X1_W-1:0]       x1_nxt;
  logic [QDAY_W-1:0]     q2_r;
  logic [QDAY_W-1:0]     q2_nxt;
  logic [P2_W-1:0]       p2;
  logic [DN_W-1:0]       dn3_r;
  logic [DN_W-1:0]       dn3_nxt;

  // fractional part of the mean years plus epoch bias and term offset
  assign x1_nxt = X1_W'(data_i.year) * X1_W'(YEAR_FRAC_MMIN)
                + X1_W'(term_mmin(data_i.term)) + X1_W'(BIAS_MMIN);

  // whole days in the fraction: shift out 2^8, then divide by the odd factor
  assign p2     = P2_W'(x1_r[X1_W-1:DAY_SHIFT]) * P2_W'(RCP_DAY);
  assign q2_nxt = p2[RCP_DAY_SH +: QDAY_W];

  assign dn3_nxt = DN_W'(year2_r) * DN_W'(YEAR_DAYS) + DN_W'(q2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r[0] <= data_i.term;
      term_r[1] <= term_r[0];
      term_r[2] <= term_r[1];
      year1_r   <= data_i.year;
      x1_r      <= x1_nxt;
      year2_r   <= year1_r;
      q2_r      <= q2_nxt;
      dn3_r     <= dn3_nxt;
    end
  end

  assign vld_o       = vld_r[2];
  assign data_o.dn   = dn3_r;
  assign data_o.term = term_r[2];

endmodule
`default_nettype wire

// File: rtl/sterm_estimate.sv
// seven-stage estimate of year, month and day from a day number
`timescale 1ns / 1ps
`default_nettype none
module sterm_estimate (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    vld_i,
  input  sterm_pkg::sterm_dn_t   data_i,
  output logic                   vld_o,
  output sterm_pkg::sterm_est_t  data_o
);
  import sterm_pkg::*;

  localparam int NST  = 7;
  localparam int P1_W = DN_W + RCP_CYC_W;
  localparam int P3_W = SC_W + RCP_YR_W;
  localparam int P4_W = EY_W + RCP_C_W;
  localparam int P5_W = REM_W + RCP_MON_W;
  localparam int P7_W = REM2_W + RCP_DS_W;

  logic [NST-1:0]      vld_r;
  sterm_dn_t           tag_r [NST];

  logic [P1_W-1:0]     p1;
  logic [QCYC_W-1:0]   q1_r;
  logic [SC_W-1:0]     sc2_r;
  logic [SC_W-1:0]     sc2_nxt;
  logic [P3_W-1:0]     p3;
  logic [EY_W-1:0]     y3_r;
  logic [SC_W-1:0]     sc3_r;
  logic [REM_W-1:0]    rem4_nxt;
  logic [P4_W-1:0]     p4c;
  logic [P4_W-1:0]     p4q;
  logic [REM_W-1:0]    rem4_r;
  logic [EY_W-1:0]     y4_r;
  logic [Q100_W-1:0]   y100_4_r;
  logic [Q400_W-1:0]   y400_4_r;
  logic [P5_W-1:0]     p5;
  logic [QM_W-1:0]     qm5_r;
  logic [REM_W-1:0]    rem5_r;
  logic [EY_W-1:0]     y5_r;
  logic [Q100_W-1:0]   y100_5_r;
  logic [Q400_W-1:0]   y400_5_r;
  logic [REM2_W-1:0]   rem6_nxt;
  logic [REM2_W-1:0]   rem6_r;
  logic [QM_W-1:0]     qm6_r;
  logic [EY_W-1:0]     y6_r;
  logic [Q100_W-1:0]   y100_6_r;
  logic [Q400_W-1:0]   y400_6_r;
  logic [P7_W-1:0]     p7;
  logic [EY_W-1:0]     y7_r;
  logic [MONTH_W-1:0]  m7_r;
  logic [DAY_W-1:0]    d7_r;
  logic [Q100_W-1:0]   y100_7_r;
  logic [Q400_W-1:0]   y400_7_r;

  assign p1       = P1_W'(data_i.dn) * P1_W'(RCP_CYC);
  assign sc2_nxt  = SC_W'(tag_r[0].dn - DN_W'(q1_r)) * SC_W'(DAY_SCALE);
  assign p3       = P3_W'(sc2_r) * P3_W'(RCP_YR);
  assign rem4_nxt = REM_W'(sc3_r - SC_W'(y3_r) * SC_W'(SCALED_YEAR));
  assign p4c      = P4_W'(y3_r) * P4_W'(RCP_C);
  assign p4q      = P4_W'(y3_r) * P4_W'(RCP_Q);
  assign p5       = P5_W'(rem4_r) * P5_W'(RCP_MON);
  assign rem6_nxt = REM2_W'(rem5_r - REM_W'(qm5_r) * REM_W'(SCALED_MONTH));
  assign p7       = P7_W'(rem6_r) * P7_W'(RCP_DS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= data_i;
      for (int i = 1; i < NST; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
      q1_r     <= p1[RCP_CYC_SH +: QCYC_W];
      sc2_r    <= sc2_nxt;
      y3_r     <= p3[RCP_YR_SH +: EY_W];
      sc3_r    <= sc2_r;
      rem4_r   <= rem4_nxt;
      y4_r     <= y3_r;
      y100_4_r <= p4c[RCP_C_SH +: Q100_W];
      y400_4_r <= p4q[RCP_Q_SH +: Q400_W];
      qm5_r    <= p5[RCP_MON_SH +: QM_W];
      rem5_r   <= rem4_r;
      y5_r     <= y4_r;
      y100_5_r <= y100_4_r;
      y400_5_r <= y400_4_r;
      rem6_r   <= rem6_nxt;
      qm6_r    <= qm5_r;
      y6_r     <= y5_r;
      y100_6_r <= y100_5_r;
      y400_6_r <= y400_5_r;
      y7_r     <= y6_r;
      m7_r     <= qm6_r + MONTH_W'(1);
      d7_r     <= DAY_W'(p7[RCP_DS_SH +: DAY_W]) + DAY_W'(1);
      y100_7_r <= y100_6_r;
      y400_7_r <= y400_6_r;
    end
  end

  assign vld_o       = vld_r[NST-1];
  assign data_o.y    = y7_r;
  assign data_o.m    = m7_r;
  assign data_o.d    = d7_r;
  assign data_o.y100 = y100_7_r;
  assign data_o.y400 = y400_7_r;
  assign data_o.dn   = tag_r[NST-1].dn;
  assign data_o.term = tag_r[NST-1].term;

endmodule
`default_nettype wire

// File: rtl/sterm_adjust.sv
// three-stage day error check and one-month correction, last stage is the output register
`timescale 1ns / 1ps
`default_nettype none
module sterm_adjust (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    en,
  input  wire                    vld_i,
  input  sterm_pkg::sterm_est_t  data_i,
  output logic                   vld_o,
  output sterm_pkg::sterm_out_t  data_o
);
  import sterm_pkg::*;

  logic [2:0]                vld_r;
  sterm_est_t                e1_r;
  sterm_est_t                e2_r;
  logic                      leap1_r;
  logic                      leap1_nxt;
  logic                      leap2_r;
  logic [EY_W-1:0]           yc100;
  logic [EY_W-1:0]           yc400;
  logic [DIFF_W-1:0]         base1_r;
  logic [DIFF_W-1:0]         base1_nxt;
  logic signed [DIFF_W-1:0]  diff2_r;
  logic signed [DIFF_W-1:0]  diff2_nxt;

  logic signed [DIFF_W-1:0]  ds;
  logic signed [DIFF_W-1:0]  bdiff;
  logic signed [DIFF_W-1:0]  plen;
  logic signed [DIFF_W-1:0]  d_back;
  logic signed [DIFF_W-1:0]  df;
  logic signed [DIFF_W-1:0]  clen;
  logic signed [DIFF_W-1:0]  d_fwd;
  logic                      go_back;
  logic                      spill;
  logic [MONTH_W-1:0]        m_prev;
  logic [MONTH_W-1:0]        m_next;
  sterm_out_t                res_nxt;
  sterm_out_t                res_r;

  assign yc100     = EY_W'(data_i.y100) * EY_W'(CENTURY);
  assign yc400     = EY_W'(data_i.y400) * EY_W'(QUAD_CENTURY);
  assign leap1_nxt = ((data_i.y[1:0] == 2'b00) && (data_i.y != yc100))
                   || (data_i.y == yc400);
  assign base1_nxt = DIFF_W'(data_i.y) * DIFF_W'(YEAR_DAYS) + DIFF_W'(data_i.y >> 2)
                   - DIFF_W'(data_i.y100) + DIFF_W'(data_i.y400);

  // estimated date minus the day number, in days
  assign diff2_nxt = base1_r + DIFF_W'(days_before(e1_r.m)) + DIFF_W'(e1_r.d)
                   - DIFF_W'(leap1_r && (e1_r.m <= FEBRUARY)) - DIFF_W'(e1_r.dn);

  assign ds      = DIFF_W'(e2_r.d);
  assign go_back = (diff2_r > 0) && (diff2_r >= ds);
  assign m_prev  = (e2_r.m == JANUARY) ? DECEMBER : e2_r.m - MONTH_W'(1);
  assign m_next  = (e2_r.m == DECEMBER) ? JANUARY : e2_r.m + MONTH_W'(1);
  assign bdiff   = diff2_r - ds;
  assign plen    = DIFF_W'(month_len(m_prev, leap2_r));
  assign d_back  = plen - bdiff;
  assign df      = ds - diff2_r;
  assign clen    = DIFF_W'(month_len(e2_r.m, leap2_r));
  assign spill   = df > clen;
  assign d_fwd   = spill ? df - clen : df;

  always_comb begin
    res_nxt.term = e2_r.term;
    if (go_back) begin
      res_nxt.month = m_prev;
      res_nxt.day   = d_back[DAY_W-1:0];
      if (e2_r.m == JANUARY) begin
        res_nxt.year = YEAR_W'(e2_r.y - EY_W'(1));
      end else begin
        res_nxt.year = e2_r.y[YEAR_W-1:0];
      end
    end else begin
      res_nxt.day = d_fwd[DAY_W-1:0];
      if (spill) begin
        res_nxt.month = m_next;
      end else begin
        res_nxt.month = e2_r.m;
      end
      if (spill && (e2_r.m == DECEMBER)) begin
        res_nxt.year = YEAR_W'(e2_r.y + EY_W'(1));
      end else begin
        res_nxt.year = e2_r.y[YEAR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r    <= data_i;
      leap1_r <= leap1_nxt;
      base1_r <= base1_nxt;
      e2_r    <= e1_r;
      leap2_r <= leap1_r;
      diff2_r <= diff2_nxt;
      res_r   <= res_nxt;
    end
  end

  assign vld_o  = vld_r[2];
  assign data_o = res_r;

endmodule
`default_nettype wire

// File: rtl/solar_term_date.sv
// top level of the solar term date pipeline
//
// in channel: one query per transfer, tdata carries the gregorian year and
// the solar term index (0 minor cold .. 23 winter solstice, higher indices
// use the winter solstice offset).
// out channel: one result per query, in query order, with the date of the
// term and the index echoed back unchanged.
// pipeline: 13 register stages (3 day number stages, 7 estimate stages,
// 3 correction stages, the last of which is the output register).
// throughput: one query per cycle while the output is not stalled; all
// multiplies are by constants, side by side where a stage has more than one.
// stall: while out_tvalid is high and out_tready low the whole pipeline
// holds, in_tready drops and nothing is lost or repeated.
// reset: rst_n low for one cycle clears all valid bits; the data registers
// are not reset.
`timescale 1ns / 1ps
`default_nettype none
module solar_term_date (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [sterm_pkg::IN_W-1:0]   in_tdata,   // year[13:0], term_index[18:14]
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [sterm_pkg::OUT_W-1:0]  out_tdata   // out_year[13:0], out_month[17:14],
                                                    // out_day[22:18], term_echo[27:23]
);
  import sterm_pkg::*;

  logic        en;
  sterm_in_t   query;
  logic        dn_vld;
  sterm_dn_t   dn_item;
  logic        est_vld;
  sterm_est_t  est_item;
  logic        res_vld;
  sterm_out_t  res_item;

  assign en         = !res_vld || out_tready;
  assign in_tready  = en;

  assign query.year = in_tdata[YEAR_W-1:0];
  assign query.term = in_tdata[YEAR_W +: TERM_W];

  sterm_daynum u_daynum (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_tvalid),
    .data_i (query),
    .vld_o  (dn_vld),
    .data_o (dn_item)
  );

  sterm_estimate u_estimate (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (dn_vld),
    .data_i (dn_item),
    .vld_o  (est_vld),
    .data_o (est_item)
  );

  sterm_adjust u_adjust (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (est_vld),
    .data_i (est_item),
    .vld_o  (res_vld),
    .data_o (res_item)
  );

  assign out_tvalid = res_vld;
  assign out_tdata  = {OUT_PAD'(0), res_item.term, res_item.day,
                       res_item.month, res_item.year};

endmodule
`default_nettype wire

// File: rtl/sterm_checker.sv
// port-level checks for the solar term date block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sterm_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_tready,
  input wire                          out_tvalid,
  input wire                          out_tready,
  input wire [sterm_pkg::OUT_W-1:0]   out_tdata
);
  import sterm_pkg::*;

  `STERM_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_tvalid, "result valid after reset")
  `STERM_ASSERT(a_ready_follows_out, in_tready == (!out_tvalid || out_tready), "in_tready mismatch")
  `STERM_ASSERT(a_month_range, out_tvalid |-> (out_tdata[YEAR_W +: MONTH_W] >= JANUARY && out_tdata[YEAR_W +: MONTH_W] <= DECEMBER), "month out of range")
  `STERM_ASSERT(a_stall_holds, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind solar_term_date sterm_checker u_sterm_checker (.*);
`default_nettype wire
